[hw/rtl/cbm_pkg.sv]
// cbm_pkg: shared types and constants for the cartridge bank mapper.
// No dependencies; used by cbm_decode, cbm_mod_unit and cartridge_bank_mapper.
`default_nettype none

package cbm_pkg;

    // Field widths of the access and result beats
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int PHYS_W   = 21;
    localparam int ROMB_W   = 7;
    localparam int RAMB_W   = 4;
    localparam int CNT_W    = 8;
    localparam int RAMCNT_W = 3;
    localparam int KIND_W   = 2;

    // Bank number fed to the remainder unit: 2-bit upper bank and 5-bit bank
    localparam int BANK_W   = 7;
    localparam int STEP_W   = $clog2(BANK_W);

    // Bank shifts: 16 KiB ROM banks, 8 KiB RAM banks
    localparam int ROM_SHIFT = 14;
    localparam int RAM_SHIFT = 13;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAPPER_KIND = 2'd0;
    localparam logic [1:0] CFG_ROM_COUNT   = 2'd1;
    localparam logic [1:0] CFG_RAM_COUNT   = 2'd2;
    localparam logic [1:0] CFG_CART        = 2'd3;

    // Mapper kinds
    localparam logic [KIND_W-1:0] MAP_PLAIN   = 2'd0;
    localparam logic [KIND_W-1:0] MAP_MBC1    = 2'd1;
    localparam logic [KIND_W-1:0] MAP_MBC3    = 2'd2;
    localparam logic [KIND_W-1:0] MAP_UNKNOWN = 2'd3;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Result targets
    localparam logic [1:0] TGT_SYS_RAM  = 2'd0;
    localparam logic [1:0] TGT_ROM      = 2'd1;
    localparam logic [1:0] TGT_CART_RAM = 2'd2;
    localparam logic [1:0] TGT_NONE     = 2'd3;

    // Control range select, address[14:13] below 0x8000
    localparam logic [1:0] CTL_ENABLE = 2'd0;
    localparam logic [1:0] CTL_ROMB   = 2'd1;
    localparam logic [1:0] CTL_RAMB   = 2'd2;
    localparam logic [1:0] CTL_MODE   = 2'd3;

    localparam logic [3:0]        RAM_ENABLE_KEY = 4'hA;
    localparam logic [DATA_W-1:0] FIXED_FF       = 8'hFF;
    localparam logic [DATA_W-1:0] FIXED_ZERO     = 8'h00;

    // Decoded access: base result, remainder request and register updates
    typedef struct packed {
        logic [1:0]        target;
        logic [PHYS_W-1:0] phys;
        logic              strobe;
        logic [DATA_W-1:0] fixed;
        logic              use_mod;
        logic              ram_side;
        logic [BANK_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
        logic              set_enable;
        logic              enable_value;
        logic              set_rom;
        logic [ROMB_W-1:0] rom_value;
        logic              set_ram;
        logic [RAMB_W-1:0] ram_value;
        logic              set_mode;
        logic              mode_value;
    } decode_t;

    // Status of the shared remainder unit
    typedef struct packed {
        logic              busy;
        logic [BANK_W-1:0] remainder;
    } mod_status_t;

endpackage

`default_nettype wire

[hw/rtl/cartridge_bank_mapper.sv]
// cartridge_bank_mapper: top level of the cartridge memory bank controller.
// Depends on cbm_pkg, cbm_decode and cbm_mod_unit.
//
//   Channel  | Direction | Handshake          | Beat contents
//   ---------+-----------+--------------------+----------------------------------------
//   in       | to block  | in_valid/in_stall  | op, address, write_data
//   out      | from block| out_valid/out_stall| target, phys_address, store_strobe,
//            |           |                    | fixed_value, bank/flag state after access
//   cfg      | to block  | cfg_we             | cfg_index, cfg_data (no read-back)
//
// Each access holds in_stall from its accepted beat to the next accept: the
// shared remainder unit takes one bit of the 7-bit bank number per cycle,
// then the output register loads, once free, as the sequencer returns to idle.
// Reset clears the configuration to plain mode with no cartridge, ROM bank 1,
// RAM bank 0, RAM disabled and mode 0; no clearing pass is needed.
// A stalled result holds in the output register; the next access is taken
// while it waits, and its result holds until the output register frees up.
`default_nettype none

module cartridge_bank_mapper
#(
    parameter int MAX_ROM_BANKS = 128,
    parameter int MAX_RAM_BANKS = 4
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [cbm_pkg::DATA_W-1:0]    cfg_data,

    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic                          op,
    input  wire logic [cbm_pkg::ADDR_W-1:0]    address,
    input  wire logic [cbm_pkg::DATA_W-1:0]    write_data,

    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [1:0]                    target,
    output      logic [cbm_pkg::PHYS_W-1:0]    phys_address,
    output      logic                          store_strobe,
    output      logic [cbm_pkg::DATA_W-1:0]    fixed_value,
    output      logic [cbm_pkg::ROMB_W-1:0]    rom_bank_now,
    output      logic [cbm_pkg::RAMB_W-1:0]    ram_bank_now,
    output      logic                          ram_on,
    output      logic                          bank_mode
);

    typedef enum logic
    {
        S_IDLE,
        S_RUN
    } state_t;

    // Configuration registers
    logic [cbm_pkg::KIND_W-1:0]   mapper_kind_reg;
    logic [cbm_pkg::CNT_W-1:0]    rom_count_reg;
    logic [cbm_pkg::RAMCNT_W-1:0] ram_count_reg;
    logic                         cart_reg;

    // Mapper state
    logic [cbm_pkg::ROMB_W-1:0]   rom_bank_reg;
    logic [cbm_pkg::RAMB_W-1:0]   ram_bank_reg;
    logic                         ram_enable_reg;
    logic                         mode_reg;

    // Sequencer and held access
    state_t                       state_reg;
    cbm_pkg::decode_t             dec;
    cbm_pkg::decode_t             dec_reg;
    cbm_pkg::mod_status_t         mod_status;

    // Output register; the bank state is captured with the result so a
    // following control write cannot disturb a waiting beat
    logic                         out_valid_reg;
    logic [1:0]                   target_reg;
    logic [cbm_pkg::PHYS_W-1:0]   phys_reg;
    logic                         strobe_reg;
    logic [cbm_pkg::DATA_W-1:0]   fixed_reg;
    logic [cbm_pkg::ROMB_W-1:0]   rom_now_reg;
    logic [cbm_pkg::RAMB_W-1:0]   ram_now_reg;
    logic                         ram_on_reg;
    logic                         mode_now_reg;

    logic                         in_accept;
    logic                         out_free;
    logic                         load_out;
    logic [cbm_pkg::PHYS_W-1:0]   bank_base;
    logic [cbm_pkg::PHYS_W-1:0]   phys_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == S_RUN) && !mod_status.busy && out_free;

    cbm_decode
    #(
        .MAX_ROM_BANKS (MAX_ROM_BANKS),
        .MAX_RAM_BANKS (MAX_RAM_BANKS)
    )
    u_decode
    (
        .op             (op),
        .address        (address),
        .write_data     (write_data),
        .mapper_kind    (mapper_kind_reg),
        .rom_bank_count (rom_count_reg),
        .ram_bank_count (ram_count_reg),
        .cart_present   (cart_reg),
        .rom_page       (rom_bank_reg),
        .ram_page       (ram_bank_reg),
        .ram_enable     (ram_enable_reg),
        .mode           (mode_reg),
        .dec            (dec)
    );

    // Wrap the bank number by the bank count; runs for every access so the
    // latency does not depend on the access kind
    cbm_mod_unit u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .dividend (dec.dividend),
        .divisor  (dec.divisor),
        .status   (mod_status)
    );

    // Place the wrapped bank above the in-bank offset
    always_comb
    begin
        if (dec_reg.ram_side)
        begin
            bank_base = cbm_pkg::PHYS_W'(mod_status.remainder[1:0]) << cbm_pkg::RAM_SHIFT;
        end
        else
        begin
            bank_base = cbm_pkg::PHYS_W'(mod_status.remainder) << cbm_pkg::ROM_SHIFT;
        end
        phys_next = dec_reg.use_mod ? (dec_reg.phys | bank_base) : dec_reg.phys;
    end

    // Configuration writes must arrive only while idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_kind_reg <= cbm_pkg::MAP_PLAIN;
            rom_count_reg   <= cbm_pkg::CNT_W'(2);
            ram_count_reg   <= '0;
            cart_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbm_pkg::CFG_MAPPER_KIND: mapper_kind_reg <= cfg_data[cbm_pkg::KIND_W-1:0];
                cbm_pkg::CFG_ROM_COUNT:   rom_count_reg   <= cfg_data;
                cbm_pkg::CFG_RAM_COUNT:   ram_count_reg   <= cfg_data[cbm_pkg::RAMCNT_W-1:0];
                cbm_pkg::CFG_CART:        cart_reg        <= cfg_data[0];
            endcase
        end
    end

    // Sequencer, mapper state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            rom_bank_reg   <= cbm_pkg::ROMB_W'(1);
            ram_bank_reg   <= '0;
            ram_enable_reg <= 1'b0;
            mode_reg       <= 1'b0;
            target_reg     <= '0;
            phys_reg       <= '0;
            strobe_reg     <= 1'b0;
            fixed_reg      <= '0;
            rom_now_reg    <= '0;
            ram_now_reg    <= '0;
            ram_on_reg     <= 1'b0;
            mode_now_reg   <= 1'b0;
        end
        else
        begin
            // Fill the output register, or drop a beat the receiver took
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                target_reg    <= dec_reg.target;
                phys_reg      <= phys_next;
                strobe_reg    <= dec_reg.strobe;
                fixed_reg     <= dec_reg.fixed;
                rom_now_reg   <= rom_bank_reg;
                ram_now_reg   <= ram_bank_reg;
                ram_on_reg    <= ram_enable_reg;
                mode_now_reg  <= mode_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        // Apply control writes now; the result reports the new state
                        if (dec.set_enable) ram_enable_reg <= dec.enable_value;
                        if (dec.set_rom)    rom_bank_reg   <= dec.rom_value;
                        if (dec.set_ram)    ram_bank_reg   <= dec.ram_value;
                        if (dec.set_mode)   mode_reg       <= dec.mode_value;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Held access
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dec_reg <= dec;
        end
    end

    assign out_valid    = out_valid_reg;
    assign target       = target_reg;
    assign phys_address = phys_reg;
    assign store_strobe = strobe_reg;
    assign fixed_value  = fixed_reg;
    assign rom_bank_now = rom_now_reg;
    assign ram_bank_now = ram_now_reg;
    assign ram_on       = ram_on_reg;
    assign bank_mode    = mode_now_reg;

endmodule

`default_nettype wire

[hw/rtl/cbm_mod_unit.sv]
// cbm_mod_unit: shared restoring remainder unit, one quotient bit per cycle.
// Depends on cbm_pkg.
`default_nettype none

module cbm_mod_unit
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [cbm_pkg::BANK_W-1:0]   dividend,
    input  wire logic [cbm_pkg::CNT_W-1:0]    divisor,
    output cbm_pkg::mod_status_t              status
);

    logic                        busy_reg;
    logic [cbm_pkg::STEP_W-1:0]  step_reg;
    logic [cbm_pkg::BANK_W-1:0]  shift_reg;
    logic [cbm_pkg::BANK_W-1:0]  rem_reg;
    logic [cbm_pkg::CNT_W-1:0]   div_reg;

    logic [cbm_pkg::BANK_W:0]    trial;
    logic [cbm_pkg::BANK_W-1:0]  rem_next;

    // Shift in the next dividend bit and subtract when it fits
    always_comb
    begin
        trial = {rem_reg, shift_reg[cbm_pkg::BANK_W-1]};
        if (trial >= div_reg)
        begin
            rem_next = cbm_pkg::BANK_W'(trial - div_reg);
        end
        else
        begin
            rem_next = trial[cbm_pkg::BANK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= cbm_pkg::STEP_W'(cbm_pkg::BANK_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[cbm_pkg::BANK_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign status.busy      = busy_reg;
    assign status.remainder = rem_reg;

endmodule

`default_nettype wire

[hw/rtl/cbm_decode.sv]
// cbm_decode: classifies one bus access by mapper kind and address range.
// Depends on cbm_pkg; bank wrapping is left to cbm_mod_unit.
`default_nettype none

module cbm_decode
#(
    parameter int MAX_ROM_BANKS = 128,
    parameter int MAX_RAM_BANKS = 4
)
(
    input  wire logic                            op,
    input  wire logic [cbm_pkg::ADDR_W-1:0]      address,
    input  wire logic [cbm_pkg::DATA_W-1:0]      write_data,
    input  wire logic [cbm_pkg::KIND_W-1:0]      mapper_kind,
    input  wire logic [cbm_pkg::CNT_W-1:0]       rom_bank_count,
    input  wire logic [cbm_pkg::RAMCNT_W-1:0]    ram_bank_count,
    input  wire logic                            cart_present,
    input  wire logic [cbm_pkg::ROMB_W-1:0]      rom_page,
    input  wire logic [cbm_pkg::RAMB_W-1:0]      ram_page,
    input  wire logic                            ram_enable,
    input  wire logic                            mode,
    output cbm_pkg::decode_t                     dec
);

    logic [cbm_pkg::CNT_W-1:0]    rom_eff;
    logic [cbm_pkg::RAMCNT_W-1:0] ram_eff;
    logic                         wr;
    logic                         ctl_range;
    logic                         low_rom;
    logic                         high_rom;
    logic                         cart_ram;
    logic [1:0]                   upper;
    logic [1:0]                   ctl_sel;
    logic [cbm_pkg::PHYS_W-1:0]   bus_phys;

    always_comb
    begin
        // Clamp bank counts; zero ROM banks acts as one
        if (rom_bank_count == '0)
        begin
            rom_eff = cbm_pkg::CNT_W'(1);
        end
        else if (rom_bank_count > cbm_pkg::CNT_W'(MAX_ROM_BANKS))
        begin
            rom_eff = cbm_pkg::CNT_W'(MAX_ROM_BANKS);
        end
        else
        begin
            rom_eff = rom_bank_count;
        end

        if (ram_bank_count > cbm_pkg::RAMCNT_W'(MAX_RAM_BANKS))
        begin
            ram_eff = cbm_pkg::RAMCNT_W'(MAX_RAM_BANKS);
        end
        else
        begin
            ram_eff = ram_bank_count;
        end

        wr        = (op == cbm_pkg::OP_WRITE);
        ctl_range = !address[15];
        low_rom   = (address[15:14] == 2'b00);
        high_rom  = (address[15:14] == 2'b01);
        cart_ram  = (address[15:13] == 3'b101);
        upper     = ram_page[1:0];
        ctl_sel   = address[14:13];
        bus_phys  = cbm_pkg::PHYS_W'(address);

        dec              = '0;
        dec.target       = cbm_pkg::TGT_NONE;
        dec.divisor      = cbm_pkg::CNT_W'(1);
        dec.enable_value = (write_data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
        dec.mode_value   = write_data[0];

        if (!cart_present)
        begin
            dec.target = cbm_pkg::TGT_SYS_RAM;
            dec.phys   = bus_phys;
            dec.strobe = wr;
        end
        else
        begin
            unique case (mapper_kind)
                cbm_pkg::MAP_PLAIN:
                begin
                    // Writes into the ROM window are dropped
                    if (!wr || !ctl_range)
                    begin
                        dec.target = cbm_pkg::TGT_SYS_RAM;
                        dec.phys   = bus_phys;
                        dec.strobe = wr;
                    end
                end
                cbm_pkg::MAP_MBC1:
                begin
                    if (wr && ctl_range)
                    begin
                        unique case (ctl_sel)
                            cbm_pkg::CTL_ENABLE: dec.set_enable = 1'b1;
                            cbm_pkg::CTL_ROMB:
                            begin
                                dec.set_rom   = 1'b1;
                                dec.rom_value = (write_data[4:0] == 5'd0) ?
                                                cbm_pkg::ROMB_W'(1) :
                                                cbm_pkg::ROMB_W'(write_data[4:0]);
                            end
                            cbm_pkg::CTL_RAMB:
                            begin
                                dec.set_ram   = 1'b1;
                                dec.ram_value = cbm_pkg::RAMB_W'(write_data[1:0]);
                            end
                            cbm_pkg::CTL_MODE:   dec.set_mode = 1'b1;
                        endcase
                    end
                    else if (low_rom)
                    begin
                        dec.target   = cbm_pkg::TGT_ROM;
                        dec.phys     = bus_phys;
                        dec.use_mod  = 1'b1;
                        dec.dividend = mode ? {upper, 5'd0} : '0;
                        dec.divisor  = rom_eff;
                    end
                    else if (high_rom)
                    begin
                        dec.target   = cbm_pkg::TGT_ROM;
                        dec.phys     = cbm_pkg::PHYS_W'(address[13:0]);
                        dec.use_mod  = 1'b1;
                        dec.dividend = {upper, rom_page[4:0]};
                        dec.divisor  = rom_eff;
                    end
                    else if (cart_ram)
                    begin
                        if (ram_enable && (ram_eff != '0))
                        begin
                            dec.target   = cbm_pkg::TGT_CART_RAM;
                            dec.phys     = cbm_pkg::PHYS_W'(address[12:0]);
                            dec.strobe   = wr;
                            dec.use_mod  = 1'b1;
                            dec.ram_side = 1'b1;
                            dec.dividend = mode ? cbm_pkg::BANK_W'(upper) : '0;
                            dec.divisor  = cbm_pkg::CNT_W'(ram_eff);
                        end
                        else if (!wr)
                        begin
                            dec.fixed = cbm_pkg::FIXED_FF;
                        end
                    end
                    else
                    begin
                        dec.target = cbm_pkg::TGT_SYS_RAM;
                        dec.phys   = bus_phys;
                        dec.strobe = wr;
                    end
                end
                cbm_pkg::MAP_MBC3:
                begin
                    if (wr && ctl_range)
                    begin
                        // Clock latch range has no effect
                        unique case (ctl_sel)
                            cbm_pkg::CTL_ENABLE: dec.set_enable = 1'b1;
                            cbm_pkg::CTL_ROMB:
                            begin
                                dec.set_rom   = 1'b1;
                                dec.rom_value = (write_data[6:0] == 7'd0) ?
                                                cbm_pkg::ROMB_W'(1) : write_data[6:0];
                            end
                            cbm_pkg::CTL_RAMB:
                            begin
                                dec.set_ram   = 1'b1;
                                dec.ram_value = write_data[3:0];
                            end
                            cbm_pkg::CTL_MODE: ;
                        endcase
                    end
                    else if (low_rom)
                    begin
                        dec.target = cbm_pkg::TGT_ROM;
                        dec.phys   = bus_phys;
                    end
                    else if (high_rom)
                    begin
                        dec.target = cbm_pkg::TGT_ROM;
                        dec.phys   = {rom_page, address[13:0]};
                    end
                    else if (cart_ram)
                    begin
                        if (ram_enable && (ram_page[3:2] == 2'b00) &&
                            (cbm_pkg::RAMCNT_W'(ram_page[1:0]) < ram_eff))
                        begin
                            dec.target = cbm_pkg::TGT_CART_RAM;
                            dec.phys   = cbm_pkg::PHYS_W'({ram_page[1:0], address[12:0]});
                            dec.strobe = wr;
                        end
                    end
                    else
                    begin
                        dec.target = cbm_pkg::TGT_SYS_RAM;
                        dec.phys   = bus_phys;
                        dec.strobe = wr;
                    end
                end
                cbm_pkg::MAP_UNKNOWN:
                begin
                    if (!wr)
                    begin
                        dec.fixed = cbm_pkg::FIXED_FF;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cbm_checker.sv]
// cbm_checker: port-level assertions for cartridge_bank_mapper, bound below.
// Depends on cbm_pkg and the top level's port list.
`default_nettype none

module cbm_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [1:0]                    target,
    input  wire logic [cbm_pkg::PHYS_W-1:0]    phys_address,
    input  wire logic                          store_strobe,
    input  wire logic [cbm_pkg::DATA_W-1:0]    fixed_value
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(target) &&
        $stable(phys_address) && $stable(store_strobe) && $stable(fixed_value))
        else $error("result beat changed while stalled");

    // One access at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an access is in progress");

    // No target means no address and no store
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target == cbm_pkg::TGT_NONE) |-> (phys_address == '0) && !store_strobe)
        else $error("address or store on a result with no target");

    // A fixed value only comes with no target
    a_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fixed_value != '0) |-> (target == cbm_pkg::TGT_NONE))
        else $error("fixed value on a mapped result");

    // ROM is never written
    a_rom_ro: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target == cbm_pkg::TGT_ROM) |-> !store_strobe)
        else $error("store to cartridge ROM");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .target       (target),
    .phys_address (phys_address),
    .store_strobe (store_strobe),
    .fixed_value  (fixed_value)
);

`default_nettype wire
